>>> sv/dsff_pkg.sv
// ----------------------------------------------------------------------------
// dsff_pkg
// shared types and codes of the duplicate set forwarding filter
// ----------------------------------------------------------------------------
`default_nettype none

package dsff_pkg;

    localparam logic CMD_MESSAGE = 1'b0;
    localparam logic CMD_TICK    = 1'b1;

    localparam logic [1:0] STATUS_OK          = 2'd0;
    localparam logic [1:0] STATUS_TABLE_FULL  = 2'd1;
    localparam logic [1:0] STATUS_IFACE_FULL  = 2'd2;

    localparam logic [15:0] HOLD_TIME_RESET = 16'd30;

    typedef struct packed {
        logic        cmd;
        logic [31:0] originator_addr;
        logic [15:0] message_seq;
        logic [31:0] receive_iface_addr;
        logic        sender_symmetric;
        logic        sender_mpr_selector;
        logic [7:0]  time_to_live;
    } in_item_t;

    typedef struct packed {
        logic       retransmit;
        logic       was_duplicate;
        logic [1:0] status;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_IFACE,
        ST_DECIDE,
        ST_TICK,
        ST_DONE
    } state_t;

endpackage

`default_nettype wire

>>> sv/duplicate_set_forwarding_filter.sv
// ----------------------------------------------------------------------------
// duplicate_set_forwarding_filter
// duplicate set with default forwarding decision, one entry visited per cycle
// ----------------------------------------------------------------------------
//  channel  | signals                         | direction
//  in       | in_valid, in_ready, in_data     | item transfer into the block
//  out      | out_valid, out_ready, out_data  | result transfer out
//  cfg      | hold_time_we, hold_time_wdata   | hold time register write
//
//  a message runs a key scan (one entry compared per cycle), then an
//  interface list scan of the hit entry, up to IFACES_PER_ENTRY words, then a
//  decide state and a done state
//  a tick scans all ENTRIES entries, one timer aged per cycle, then a done state
//  reset clears valid bits and loads the default hold time; the result waits
//  in an output register while out_ready is low, and no new item is taken
//  until it goes
// ----------------------------------------------------------------------------
`default_nettype none

module duplicate_set_forwarding_filter
    import dsff_pkg::*;
#(
    parameter int ENTRIES          = 16,
    parameter int IFACES_PER_ENTRY = 4
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_ready,
    input  wire in_item_t  in_data,
    output logic           out_valid,
    input  wire logic      out_ready,
    output out_item_t      out_data,
    input  wire logic      hold_time_we,
    input  wire logic [15:0] hold_time_wdata
);

    localparam int EW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int IW = (IFACES_PER_ENTRY > 1) ? $clog2(IFACES_PER_ENTRY) : 1;
    localparam int CW = $clog2(IFACES_PER_ENTRY + 1);
    localparam int AW = $clog2(ENTRIES * IFACES_PER_ENTRY);

    // entry stores; one entry read per cycle at the scan pointer
    logic [ENTRIES-1:0] valid_reg;
    logic [31:0]        orig_mem  [ENTRIES];
    logic [15:0]        seq_mem   [ENTRIES];
    logic               retx_mem  [ENTRIES];
    logic [CW-1:0]      count_mem [ENTRIES];
    logic [15:0]        timer_mem [ENTRIES];
    logic [31:0]        iface_mem [ENTRIES*IFACES_PER_ENTRY];

    state_t      state_reg, state_next;
    in_item_t    item_reg;
    logic [15:0] hold_reg;
    logic [EW:0] idx_reg, idx_next;
    logic [IW:0] k_reg, k_next;
    logic        found_reg, found_next;
    logic [EW-1:0] hit_reg, hit_next;
    logic        free_reg, free_next;
    logic [EW-1:0] slot_reg, slot_next;
    logic        listed_reg, listed_next;
    out_item_t   out_reg;
    logic        out_valid_reg;
    logic [31:0] iface_q_reg;

    logic [EW-1:0] ei;
    logic [AW-1:0] iface_addr;
    logic          key_hit;
    logic          dec;
    logic [CW-1:0] hit_count;
    logic          handled;
    logic [1:0]    dec_status;

    assign ei        = idx_reg[EW-1:0];
    assign key_hit   = valid_reg[ei] && orig_mem[ei] == item_reg.originator_addr
                       && seq_mem[ei] == item_reg.message_seq;
    assign hit_count = count_mem[hit_reg];
    assign iface_addr = AW'(hit_reg) * AW'(IFACES_PER_ENTRY) + AW'(k_reg[IW-1:0]);
    assign dec = item_reg.sender_mpr_selector && (item_reg.time_to_live > 8'd1);
    assign handled = found_reg && (retx_mem[hit_reg] || listed_reg);

    // status of the decide cycle
    always_comb
    begin
        dec_status = STATUS_OK;
        if (item_reg.sender_symmetric && !handled)
        begin
            if (found_reg)
            begin
                if (hit_count >= CW'(IFACES_PER_ENTRY))
                    dec_status = STATUS_IFACE_FULL;
            end
            else if (!free_reg)
                dec_status = STATUS_TABLE_FULL;
        end
    end

    // next state
    always_comb
    begin
        state_next  = state_reg;
        idx_next    = idx_reg;
        k_next      = k_reg;
        found_next  = found_reg;
        hit_next    = hit_reg;
        free_next   = free_reg;
        slot_next   = slot_reg;
        listed_next = listed_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && !out_valid_reg)
                begin
                    idx_next    = '0;
                    k_next      = '0;
                    found_next  = 1'b0;
                    free_next   = 1'b0;
                    listed_next = 1'b0;
                    state_next  = (in_data.cmd == CMD_TICK) ? ST_TICK : ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (!found_reg && key_hit)
                begin
                    found_next = 1'b1;
                    hit_next   = ei;
                end
                if (!free_reg && !valid_reg[ei])
                begin
                    free_next = 1'b1;
                    slot_next = ei;
                end
                idx_next = idx_reg + 1'b1;
                if (idx_reg == (EW+1)'(ENTRIES - 1))
                    state_next = ST_IFACE;
            end
            ST_IFACE:
            begin
                // list word read last cycle is compared here, behind the read address
                if (k_reg != '0 && iface_q_reg == item_reg.receive_iface_addr)
                    listed_next = 1'b1;
                if (!found_reg || k_reg >= (IW+1)'(hit_count)
                    || k_reg == (IW+1)'(IFACES_PER_ENTRY))
                    state_next = ST_DECIDE;
                else
                    k_next = k_reg + 1'b1;
            end
            ST_DECIDE: state_next = ST_DONE;
            ST_TICK:
            begin
                idx_next = idx_reg + 1'b1;
                if (idx_reg == (EW+1)'(ENTRIES - 1))
                    state_next = ST_DONE;
            end
            ST_DONE: state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        in_ready  = (state_reg == ST_IDLE) && !out_valid_reg;
        out_valid = out_valid_reg;
        out_data  = out_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            valid_reg     <= '0;
            hold_reg      <= HOLD_TIME_RESET;
            out_valid_reg <= 1'b0;
            idx_reg       <= '0;
            k_reg         <= '0;
            found_reg     <= 1'b0;
            free_reg      <= 1'b0;
            listed_reg    <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            idx_reg    <= idx_next;
            k_reg      <= k_next;
            found_reg  <= found_next;
            free_reg   <= free_next;
            listed_reg <= listed_next;
            if (hold_time_we)
                hold_reg <= hold_time_wdata;
            if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;
            if (state_reg == ST_TICK && valid_reg[ei] && timer_mem[ei] <= 16'd1)
                valid_reg[ei] <= 1'b0;
            if (state_reg == ST_DECIDE && item_reg.sender_symmetric && !found_reg
                && free_reg)
                valid_reg[slot_reg] <= 1'b1;
            if (state_reg == ST_DONE)
                out_valid_reg <= 1'b1;
        end
    end

    // payload and stores
    always_ff @(posedge clk)
    begin
        hit_reg     <= hit_next;
        slot_reg    <= slot_next;
        iface_q_reg <= iface_mem[iface_addr];
        if (state_reg == ST_IDLE && in_valid && !out_valid_reg)
            item_reg <= in_data;
        if (state_reg == ST_TICK && valid_reg[ei])
        begin
            if (timer_mem[ei] <= 16'd1)
                timer_mem[ei] <= '0;
            else
                timer_mem[ei] <= timer_mem[ei] - 16'd1;
        end
        if (state_reg == ST_DECIDE)
        begin
            out_reg.retransmit    <= item_reg.sender_symmetric && !handled && dec;
            out_reg.was_duplicate <= found_reg;
            out_reg.status        <= dec_status;
            if (item_reg.sender_symmetric && !handled && dec_status == STATUS_OK)
            begin
                if (found_reg)
                begin
                    retx_mem[hit_reg]  <= dec;
                    timer_mem[hit_reg] <= hold_reg;
                    iface_mem[AW'(hit_reg) * AW'(IFACES_PER_ENTRY)
                              + AW'(hit_count)] <= item_reg.receive_iface_addr;
                    count_mem[hit_reg] <= hit_count + 1'b1;
                end
                else
                begin
                    orig_mem[slot_reg]  <= item_reg.originator_addr;
                    seq_mem[slot_reg]   <= item_reg.message_seq;
                    retx_mem[slot_reg]  <= dec;
                    iface_mem[AW'(slot_reg) * AW'(IFACES_PER_ENTRY)]
                                        <= item_reg.receive_iface_addr;
                    count_mem[slot_reg] <= CW'(1);
                    timer_mem[slot_reg] <= hold_reg;
                end
            end
        end
        if (state_reg == ST_TICK && idx_reg == '0)
            out_reg <= '0;
    end

endmodule

`default_nettype wire
